>>> rtl/fnp_pkg.sv
// Package: shared types and character constants for the FASTA nucleotide packer.
`timescale 1ns / 1ps
`default_nettype none
package fnp_pkg;

	// Characters with a meaning of their own in FASTA text
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] HEADER_CHAR  = 8'h3E;

	// Tail code offsets in three-base mode
	localparam logic [7:0] TAIL_PAIR_BASE   = 8'd64;
	localparam logic [7:0] TAIL_SINGLE_BASE = 8'd80;

	// Group mode codes
	localparam logic MODE_THREE = 1'b0;
	localparam logic MODE_FOUR  = 1'b1;

	// Two-bit base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// Number of held bases at which the next base closes a group (group size less one)
	localparam logic [1:0] LAST_SLOT_THREE = 2'd2;
	localparam logic [1:0] LAST_SLOT_FOUR  = 2'd3;

	// Classification of one text character
	typedef struct packed {
		logic       is_newline;
		logic       is_header_mark;
		logic       is_base;
		logic [1:0] base;
	} sym_t;

	// One result of the packing stage
	typedef struct packed {
		logic       valid;
		logic [7:0] code;
		logic       bad_symbol;
	} result_t;

	// Packing state made visible to the top level
	typedef struct packed {
		logic       halted;
		logic       group_mode;
		logic [1:0] bases_held;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/fnp_classify.sv
// Character classifier: maps one text byte to newline, header mark or base code.
`timescale 1ns / 1ps
`default_nettype none
module fnp_classify (
	input  wire logic [7:0]  text_byte,
	output fnp_pkg::sym_t    sym
);
	import fnp_pkg::*;

	// Decode the byte; N counts as A, lower case folds to upper
	always_comb begin
		sym                = '0;
		sym.is_newline     = (text_byte == NEWLINE_CHAR);
		sym.is_header_mark = (text_byte == HEADER_CHAR);
		unique case (text_byte)
			"A", "a", "N", "n": begin
				sym.is_base = 1'b1;
				sym.base    = BASE_A;
			end
			"C", "c": begin
				sym.is_base = 1'b1;
				sym.base    = BASE_C;
			end
			"G", "g": begin
				sym.is_base = 1'b1;
				sym.base    = BASE_G;
			end
			"T", "t": begin
				sym.is_base = 1'b1;
				sym.base    = BASE_T;
			end
			default: begin
				sym.is_base = 1'b0;
				sym.base    = BASE_A;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/fnp_core.sv
// Packing core: line state, base accumulator, tail flush and halt on bad symbols.
`timescale 1ns / 1ps
`default_nettype none
module fnp_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          group_mode_we,
	input  wire logic          group_mode_wd,
	input  wire logic          fire,
	input  wire fnp_pkg::sym_t sym,
	input  wire logic          last,
	output fnp_pkg::result_t   res,
	output fnp_pkg::status_t   status
);
	import fnp_pkg::*;

	logic       group_mode_q;
	logic       in_header_q;
	logic       at_line_start_q;
	logic [1:0] bases_held_q;
	logic [5:0] partial_q;
	logic       halted_q;

	logic       in_header_d;
	logic       at_line_start_d;
	logic [1:0] bases_held_d;
	logic [5:0] partial_d;
	logic       halted_d;
	logic [7:0] acc;
	logic [1:0] last_slot;

	assign acc       = {partial_q, sym.base};
	assign last_slot = (group_mode_q == MODE_FOUR) ? LAST_SLOT_FOUR : LAST_SLOT_THREE;

	// Work out the next state and the result for the request in hand
	always_comb begin
		in_header_d     = in_header_q;
		at_line_start_d = at_line_start_q;
		bases_held_d    = bases_held_q;
		partial_d       = partial_q;
		halted_d        = halted_q;
		res             = '0;
		if (!halted_q) begin
			priority if (sym.is_newline) begin
				in_header_d     = 1'b0;
				at_line_start_d = 1'b1;
			end else if (in_header_q) begin
				at_line_start_d = 1'b0;
			end else if (at_line_start_q && sym.is_header_mark) begin
				in_header_d     = 1'b1;
				at_line_start_d = 1'b0;
			end else if (!sym.is_base) begin
				at_line_start_d = 1'b0;
				halted_d        = 1'b1;
				res.valid       = 1'b1;
				res.bad_symbol  = 1'b1;
			end else if (bases_held_q == last_slot) begin
				at_line_start_d = 1'b0;
				res.valid       = 1'b1;
				res.code        = acc;
				bases_held_d    = 2'd0;
				partial_d       = 6'd0;
			end else begin
				at_line_start_d = 1'b0;
				bases_held_d    = bases_held_q + 2'd1;
				partial_d       = acc[5:0];
			end
			// Flush a three-base tail and start a fresh file at end of input
			if (last && !halted_d) begin
				if (!res.valid && group_mode_q == MODE_THREE && bases_held_d != 2'd0) begin
					res.valid = 1'b1;
					if (bases_held_d == 2'd2) begin
						res.code = TAIL_PAIR_BASE | {4'd0, partial_d[3:0]};
					end else begin
						res.code = TAIL_SINGLE_BASE | {6'd0, partial_d[1:0]};
					end
				end
				in_header_d     = 1'b0;
				at_line_start_d = 1'b1;
				bases_held_d    = 2'd0;
				partial_d       = 6'd0;
			end
		end
	end

	// Hold state; advance on each request, drop the open group on a mode write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_mode_q    <= MODE_FOUR;
			in_header_q     <= 1'b0;
			at_line_start_q <= 1'b1;
			bases_held_q    <= 2'd0;
			partial_q       <= 6'd0;
			halted_q        <= 1'b0;
		end else if (group_mode_we) begin
			group_mode_q <= group_mode_wd;
			bases_held_q <= 2'd0;
			partial_q    <= 6'd0;
		end else if (fire) begin
			in_header_q     <= in_header_d;
			at_line_start_q <= at_line_start_d;
			bases_held_q    <= bases_held_d;
			partial_q       <= partial_d;
			halted_q        <= halted_d;
		end
	end

	assign status.halted     = halted_q;
	assign status.group_mode = group_mode_q;
	assign status.bases_held = bases_held_q;

endmodule
`default_nettype wire

>>> rtl/fasta_nucleotide_packer.sv
// Top level: input register, packing core and output register of the FASTA packer.
`timescale 1ns / 1ps
`default_nettype none
// Packs FASTA text, one byte per request, into code bytes of two-bit bases
// (A=0, C=1, G=2, T=3, N as A, lower case folded), four per code when
// group_mode is 1 and three per code when it is 0, with 64+pair and
// 80+base tail codes on end_of_input in three-base mode. Header lines
// starting with '>' and newlines are skipped; any other byte yields one
// result with bad_symbol set and halts the block until reset. A request
// is taken every cycle unless the input stalls: it is held in the input
// register, then packed by one pass of logic into the output register,
// which offers its result, if any. Back-pressure on the output stalls the
// input only when both registers are full. The user must write group_mode
// only while idle; the block does not enforce this. A write discards an open group.
module fasta_nucleotide_packer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       group_mode_we,
	input  wire logic       group_mode,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      code,
	output logic            bad_symbol
);
	import fnp_pkg::*;

	logic       valid_s1;
	logic [7:0] text_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic [7:0] code_q;
	logic       bad_q;
	logic       advance;
	logic       fire;
	sym_t       sym;
	result_t    res;
	status_t    status;

	// The output register frees when empty or taken
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_s1 <= text_byte;
			last_s1 <= end_of_input;
		end
	end

	fnp_classify u_classify (
		.text_byte (text_s1),
		.sym       (sym)
	);

	fnp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.group_mode_we (group_mode_we),
		.group_mode_wd (group_mode),
		.fire          (fire),
		.sym           (sym),
		.last          (last_s1),
		.res           (res),
		.status        (status)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			code_q <= res.code;
			bad_q  <= res.bad_symbol;
		end
	end

	assign out_valid  = out_valid_q;
	assign code       = code_q;
	assign bad_symbol = bad_q;

`ifndef SYNTHESIS
	// A flagged symbol carries a zero code
	a_bad_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_symbol |-> code == 8'd0)
		else $error("bad symbol result with non-zero code");

	// Once halted, no further result is produced
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |-> !res.valid)
		else $error("result produced while halted");

	// Three-base mode never holds three bases
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.group_mode == MODE_THREE |-> status.bases_held != 2'd3)
		else $error("open group overran its size");

	// Input stalls only with both registers full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire
